/* rtl/wav_header_chunk_parser_unit_macros.svh */
// assertion macros for the wav header chunk parser
`ifndef WAV_HEADER_CHUNK_PARSER_UNIT_MACROS_SVH
`define WAV_HEADER_CHUNK_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define WHCP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("whcp check failed");
`define WHCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("whcp check failed");
`else
`define WHCP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WHCP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/whcp_pkg.sv */
// types and constants of the wav header chunk parser
`default_nettype none
package whcp_pkg;

	localparam int SIZE_BITS_DEF = 32;

	localparam int PRELUDE_LEN = 12;
	localparam int MIN_FILE    = 44;
	localparam int MIN_FMT     = 16;

	localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;

	localparam logic [7:0] RIFF_TAG [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
	localparam logic [7:0] WAVE_TAG [4] = '{8'h57, 8'h41, 8'h56, 8'h45};

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_PAD    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_FMT   = 2'd1,
		KIND_DATA  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_SHORT    = 3'd1,
		ERR_TAGS     = 3'd2,
		ERR_OVERRUN  = 3'd3,
		ERR_FORMAT   = 3'd4,
		ERR_MISSING  = 3'd5,
		ERR_EMPTY    = 3'd6
	} err_t;

	// format, channels, rate, bits as little-endian bytes
	typedef logic [9:0][7:0] fmt_bytes_t;

endpackage
`default_nettype wire

/* rtl/whcp_in_if.sv */
// byte channel into the parser
`default_nettype none
interface whcp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       is_last;

	modport source (output valid, output byte_value, output is_last, input ready);
	modport sink   (input valid, input byte_value, input is_last, output ready);
endinterface
`default_nettype wire

/* rtl/whcp_out_if.sv */
// result channel out of the parser
`default_nettype none
interface whcp_out_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [2:0]  error_code;
	logic [1:0]  channel_count;
	logic [30:0] sample_rate;
	logic [31:0] data_offset;
	logic [31:0] data_size;

	modport source (output valid, output ok, output error_code, output channel_count,
		output sample_rate, output data_offset, output data_size, input ready);
	modport sink   (input valid, input ok, input error_code, input channel_count,
		input sample_rate, input data_offset, input data_size, output ready);
endinterface
`default_nettype wire

/* rtl/wav_header_chunk_parser_unit.sv */
// RIFF/WAVE 16-bit PCM header parser, one file byte per beat.
// Bytes enter an input register and are parsed into a result register, so a byte is
// taken in every cycle; the beat marked is_last writes the result register.
// Only a last-flagged byte whose result register is still occupied holds the input
// side back, until the pending result is taken. After each result the parser is back
// at its reset state and the next byte starts a new file.
`default_nettype none
`include "wav_header_chunk_parser_unit_macros.svh"
module wav_header_chunk_parser_unit #(
	parameter int SIZE_BITS = whcp_pkg::SIZE_BITS_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	whcp_in_if.sink         bytes,
	whcp_out_if.source      result
);
	import whcp_pkg::*;

	localparam int PW = SIZE_BITS + 32;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// parser state
	logic [SIZE_BITS-1:0] pos_q;
	logic                 tags_q;
	phase_t               phase_q;
	logic [63:0]          hs_q;
	logic [31:0]          br_q;
	logic [4:0]           bi_q;
	kind_t                kind_q;
	fmt_bytes_t           fmt_q;
	logic [1:0]           found_q;
	logic [31:0]          doff_q;
	logic [31:0]          dsize_q;
	err_t                 ferr_q;

	logic [SIZE_BITS-1:0] pos_n;
	logic                 tags_n;
	phase_t               phase_n;
	logic [63:0]          hs_n;
	logic [31:0]          br_n;
	logic [4:0]           bi_n;
	kind_t                kind_n;
	fmt_bytes_t           fmt_n;
	logic [1:0]           found_n;
	logic [31:0]          doff_n;
	logic [31:0]          dsize_n;
	err_t                 ferr_n;
	logic                 fin;
	logic [31:0]          csize;
	logic [PW-1:0]        pos_wide;
	err_t                 err;

	// result register
	logic        res_valid_q;
	logic        ok_q;
	err_t        err_q;
	logic [1:0]  ch_q;
	logic [30:0] rate_q;
	logic [31:0] off_q;
	logic [31:0] size_q;

	logic out_free;
	logic adv;

	function automatic logic fmt_good(input logic [31:0] size, input fmt_bytes_t f);
		logic [15:0] ch;
		logic [31:0] rate;
		ch   = {f[3], f[2]};
		rate = {f[7], f[6], f[5], f[4]};
		return (size >= 32'(MIN_FMT)) && ({f[1], f[0]} == 16'd1)
			&& ({f[9], f[8]} == 16'd16) && (ch >= 16'd1) && (ch <= 16'd2)
			&& (rate != 32'd0) && !rate[31];
	endfunction

	assign out_free    = !res_valid_q || result.ready;
	assign adv         = valid_s1 && (!last_s1 || out_free);
	assign bytes.ready = !valid_s1 || adv;
	assign pos_wide    = {32'd0, pos_q};

	always_comb begin
		pos_n   = pos_q;
		tags_n  = tags_q;
		phase_n = phase_q;
		hs_n    = hs_q;
		br_n    = br_q;
		bi_n    = bi_q;
		kind_n  = kind_q;
		fmt_n   = fmt_q;
		found_n = found_q;
		doff_n  = doff_q;
		dsize_n = dsize_q;
		ferr_n  = ferr_q;
		fin     = 1'b0;

		if (pos_q < SIZE_BITS'(PRELUDE_LEN)) begin
			if (pos_q < SIZE_BITS'(4) && byte_s1 != RIFF_TAG[pos_q[1:0]])
				tags_n = 1'b0;
			if (pos_q >= SIZE_BITS'(8) && byte_s1 != WAVE_TAG[pos_q[1:0]])
				tags_n = 1'b0;
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					hs_n = {byte_s1, hs_q[63:8]};
					bi_n = bi_q + 5'd1;
					if (bi_q == 5'd7) begin
						bi_n = '0;
						if (hs_n[31:0] == ID_FMT)
							kind_n = KIND_FMT;
						else if (hs_n[31:0] == ID_DATA)
							kind_n = KIND_DATA;
						else
							kind_n = KIND_OTHER;
						if (kind_n == KIND_FMT)
							fmt_n = '0;
						br_n = hs_n[63:32];
						if (hs_n[63:32] == 32'd0)
							fin = 1'b1;
						else
							phase_n = PH_BODY;
					end
				end
				PH_BODY: begin
					if (kind_q == KIND_FMT) begin
						if (bi_q < 5'd8)
							fmt_n[{1'b0, bi_q[2:0]}] = byte_s1;
						else if (bi_q == 5'd14 || bi_q == 5'd15)
							fmt_n[{3'b100, bi_q[0]}] = byte_s1;
					end
					if (bi_q < 5'd16)
						bi_n = bi_q + 5'd1;
					br_n = br_q - 32'd1;
					if (br_n == 32'd0)
						fin = 1'b1;
				end
				PH_PAD: begin
					phase_n = PH_HEADER;
					bi_n    = '0;
				end
				default: begin
					phase_n = PH_HEADER;
				end
			endcase
		end

		csize = hs_n[63:32];

		// end of a chunk body
		if (fin) begin
			if (kind_n == KIND_FMT) begin
				if (fmt_good(csize, fmt_n))
					found_n[0] = 1'b1;
				else if (ferr_n == ERR_OK)
					ferr_n = ERR_FORMAT;
			end else if (kind_n == KIND_DATA) begin
				doff_n     = pos_wide[31:0] + 32'd1 - csize;
				dsize_n    = csize;
				found_n[1] = 1'b1;
			end
			bi_n    = '0;
			phase_n = csize[0] ? PH_PAD : PH_HEADER;
		end

		if (pos_q != '1)
			pos_n = pos_q + SIZE_BITS'(1);

		priority if (pos_n < SIZE_BITS'(MIN_FILE))
			err = ERR_SHORT;
		else if (!tags_n)
			err = ERR_TAGS;
		else if (ferr_n != ERR_OK)
			err = ferr_n;
		else if (phase_n == PH_BODY)
			err = ERR_OVERRUN;
		else if (found_n != 2'b11)
			err = ERR_MISSING;
		else if (dsize_n == 32'd0)
			err = ERR_EMPTY;
		else
			err = ERR_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.byte_value;
			last_s1 <= bytes.is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			tags_q  <= 1'b1;
			phase_q <= PH_HEADER;
			hs_q    <= '0;
			br_q    <= '0;
			bi_q    <= '0;
			kind_q  <= KIND_OTHER;
			fmt_q   <= '0;
			found_q <= '0;
			doff_q  <= '0;
			dsize_q <= '0;
			ferr_q  <= ERR_OK;
		end else if (adv) begin
			if (last_s1) begin
				pos_q   <= '0;
				tags_q  <= 1'b1;
				phase_q <= PH_HEADER;
				hs_q    <= '0;
				br_q    <= '0;
				bi_q    <= '0;
				kind_q  <= KIND_OTHER;
				fmt_q   <= '0;
				found_q <= '0;
				doff_q  <= '0;
				dsize_q <= '0;
				ferr_q  <= ERR_OK;
			end else begin
				pos_q   <= pos_n;
				tags_q  <= tags_n;
				phase_q <= phase_n;
				hs_q    <= hs_n;
				br_q    <= br_n;
				bi_q    <= bi_n;
				kind_q  <= kind_n;
				fmt_q   <= fmt_n;
				found_q <= found_n;
				doff_q  <= doff_n;
				dsize_q <= dsize_n;
				ferr_q  <= ferr_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			ok_q  <= (err == ERR_OK);
			err_q <= err;
			if (err == ERR_OK) begin
				ch_q   <= fmt_n[2][1:0];
				rate_q <= {fmt_n[7][6:0], fmt_n[6], fmt_n[5], fmt_n[4]};
				off_q  <= doff_n;
				size_q <= dsize_n;
			end else begin
				ch_q   <= '0;
				rate_q <= '0;
				off_q  <= '0;
				size_q <= '0;
			end
		end
	end

	assign result.valid         = res_valid_q;
	assign result.ok            = ok_q;
	assign result.error_code    = err_q;
	assign result.channel_count = ch_q;
	assign result.sample_rate   = rate_q;
	assign result.data_offset   = off_q;
	assign result.data_size     = size_q;

	// a body in progress always has bytes left
	`WHCP_ASSERT_IMPL(body_left_a, clk, arst_n, phase_q == PH_BODY, br_q != 32'd0)
	`WHCP_ASSERT_NEXT(last_gives_result_a, clk, arst_n, adv && last_s1, result.valid)
	`WHCP_ASSERT_IMPL(ok_fields_a, clk, arst_n, result.valid && result.ok,
		result.error_code == ERR_OK && result.channel_count != 2'd0
		&& result.sample_rate != 31'd0 && result.data_size != 32'd0)
	`WHCP_ASSERT_IMPL(bad_fields_zero_a, clk, arst_n, result.valid && !result.ok,
		result.error_code != ERR_OK && result.channel_count == 2'd0
		&& result.sample_rate == 31'd0 && result.data_offset == 32'd0
		&& result.data_size == 32'd0)

endmodule
`default_nettype wire
